// ===== rtl/alu8f_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// alu8f_pkg: shared types and constants of the eight-bit alu with flags
// beat formats, operation codes and decimal-adjust constants
// ----------------------------------------------------------------------------
package alu8f_pkg;

	typedef struct packed {
		logic z;
		logic n;
		logic h;
		logic c;
	} flags_t;

	typedef struct packed {
		logic [4:0]  op;
		logic [15:0] x;
		logic [15:0] y;
		logic [2:0]  bit_sel;
		flags_t      flags_in;
	} alu_req_t;

	typedef struct packed {
		logic [15:0] result;
		flags_t      flags_out;
	} alu_rsp_t;

	typedef enum logic [4:0] {
		OP_ADD   = 5'd0,
		OP_ADC   = 5'd1,
		OP_SUB   = 5'd2,
		OP_SBC   = 5'd3,
		OP_AND   = 5'd4,
		OP_XOR   = 5'd5,
		OP_OR    = 5'd6,
		OP_CP    = 5'd7,
		OP_RLC   = 5'd8,
		OP_RRC   = 5'd9,
		OP_RL    = 5'd10,
		OP_RR    = 5'd11,
		OP_SLA   = 5'd12,
		OP_SRA   = 5'd13,
		OP_SWAP  = 5'd14,
		OP_SRL   = 5'd15,
		OP_RLCA  = 5'd16,
		OP_RRCA  = 5'd17,
		OP_RLA   = 5'd18,
		OP_RRA   = 5'd19,
		OP_DAA   = 5'd20,
		OP_CPL   = 5'd21,
		OP_SCF   = 5'd22,
		OP_CCF   = 5'd23,
		OP_BIT   = 5'd24,
		OP_RES   = 5'd25,
		OP_SET   = 5'd26,
		OP_INC   = 5'd27,
		OP_DEC   = 5'd28,
		OP_ADD16 = 5'd29,
		OP_ADDSP = 5'd30
	} op_t;

	// decimal adjust
	localparam logic [7:0] DAA_LIMIT = 8'h99;
	localparam logic [3:0] NIB_LIMIT = 4'h9;
	localparam logic [7:0] DAA_HI    = 8'h60;
	localparam logic [7:0] DAA_LO    = 8'h06;

endpackage
`default_nettype wire

// ===== rtl/eight_bit_alu_with_flags_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eight_bit_alu_with_flags_top: pipelined eight-bit alu with z/n/h/c flags
// arithmetic, logic, rotate/shift, bit ops, daa and sixteen-bit adds
// ----------------------------------------------------------------------------
// usage: one beat on req carries an op code, operands x and y, a bit index
// and the incoming flags; exactly one beat on rsp returns the result word and
// the new flags, in order. the block takes one beat per cycle while rsp is not
// stalled; a beat accepted on req passes through the three register stages in
// turn before it can leave on rsp: operand decode and the shifter/logic unit, one
// shared sixteen-bit adder with nibble and byte carry taps, then zero detect and
// flag assembly into the output register. a stall on rsp backs up through the
// stages; req_ready falls only once all three stages hold a beat and rsp is
// stalled. eight-bit results sit in the low byte with the high byte zero; an
// unused op code returns x and the flags unchanged.
module eight_bit_alu_with_flags_top
	import alu8f_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	input  wire alu_req_t req,
	output logic          rsp_valid,
	input  wire logic     rsp_ready,
	output alu_rsp_t      rsp
);

	// stage 1: decoded adder operands plus the direct (non-adder) result
	typedef struct packed {
		logic [4:0]  op;
		flags_t      f;
		logic [15:0] opa;
		logic [15:0] opb;
		logic        cin;
		logic [15:0] dres;
		logic [7:0]  dz;
		logic        dcy;
	} s1_t;

	// stage 2: selected result, zero-detect source and raw carries
	typedef struct packed {
		logic [4:0]  op;
		flags_t      f;
		logic [15:0] res;
		logic [7:0]  zval;
		logic        h;
		logic        c;
	} s2_t;

	s1_t      s1_d, pipe_s1;
	s2_t      s2_d, pipe_s2;
	alu_rsp_t s3_d, rsp_s3;
	logic     v_s1, v_s2, v_s3;
	logic     en1, en2, en3;

	// ---------------------------------------------------------------
	// flow control: each stage moves when the one after it is free or moving
	// ---------------------------------------------------------------
	assign en3       = !v_s3 || rsp_ready;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign req_ready = en1;
	assign rsp_valid = v_s3;
	assign rsp       = rsp_s3;

	// ---------------------------------------------------------------
	// stage 1: decode, pick adder operands, shifts/logic/bit ops
	// ---------------------------------------------------------------
	always_comb begin
		logic [7:0] a;
		logic [7:0] b;
		logic       c;
		logic [7:0] mask;
		logic [7:0] corr;
		a    = req.x[7:0];
		b    = req.y[7:0];
		c    = req.flags_in.c;
		mask = 8'h01 << req.bit_sel;
		corr = 8'h00;
		s1_d      = '0;
		s1_d.op   = req.op;
		s1_d.f    = req.flags_in;
		s1_d.dres = req.x;
		case (req.op)
			OP_ADD, OP_ADC: begin
				s1_d.opa = {8'h00, a};
				s1_d.opb = {8'h00, b};
				s1_d.cin = (req.op == OP_ADC) ? c : 1'b0;
			end
			OP_SUB, OP_SBC, OP_CP: begin
				// subtract as a + ~b + ~borrow_in
				s1_d.opa = {8'h00, a};
				s1_d.opb = {8'h00, ~b};
				s1_d.cin = (req.op == OP_SBC) ? !c : 1'b1;
			end
			OP_AND: s1_d.dres = {8'h00, a & b};
			OP_XOR: s1_d.dres = {8'h00, a ^ b};
			OP_OR:  s1_d.dres = {8'h00, a | b};
			OP_RLC: begin
				s1_d.dres = {8'h00, b[6:0], b[7]};
				s1_d.dcy  = b[7];
			end
			OP_RRC: begin
				s1_d.dres = {8'h00, b[0], b[7:1]};
				s1_d.dcy  = b[0];
			end
			OP_RL: begin
				s1_d.dres = {8'h00, b[6:0], c};
				s1_d.dcy  = b[7];
			end
			OP_RR: begin
				s1_d.dres = {8'h00, c, b[7:1]};
				s1_d.dcy  = b[0];
			end
			OP_SLA: begin
				s1_d.dres = {8'h00, b[6:0], 1'b0};
				s1_d.dcy  = b[7];
			end
			OP_SRA: begin
				s1_d.dres = {8'h00, b[7], b[7:1]};
				s1_d.dcy  = b[0];
			end
			OP_SWAP: s1_d.dres = {8'h00, b[3:0], b[7:4]};
			OP_SRL: begin
				s1_d.dres = {8'h00, 1'b0, b[7:1]};
				s1_d.dcy  = b[0];
			end
			OP_RLCA: begin
				s1_d.dres = {8'h00, a[6:0], a[7]};
				s1_d.dcy  = a[7];
			end
			OP_RRCA: begin
				s1_d.dres = {8'h00, a[0], a[7:1]};
				s1_d.dcy  = a[0];
			end
			OP_RLA: begin
				s1_d.dres = {8'h00, a[6:0], c};
				s1_d.dcy  = a[7];
			end
			OP_RRA: begin
				s1_d.dres = {8'h00, c, a[7:1]};
				s1_d.dcy  = a[0];
			end
			OP_DAA: begin
				s1_d.opa = {8'h00, a};
				s1_d.dcy = c;
				if (req.flags_in.n) begin
					if (req.flags_in.h) corr = corr | DAA_LO;
					if (c) corr = corr | DAA_HI;
					s1_d.opb = {8'h00, ~corr};
					s1_d.cin = 1'b1;
				end else begin
					if (req.flags_in.h || (a[3:0] > NIB_LIMIT)) corr = corr | DAA_LO;
					if (c || (a > DAA_LIMIT)) begin
						corr     = corr | DAA_HI;
						s1_d.dcy = 1'b1;
					end
					s1_d.opb = {8'h00, corr};
				end
			end
			OP_CPL:         s1_d.dres = {8'h00, ~a};
			OP_SCF, OP_CCF: s1_d.dres = {8'h00, a};
			OP_BIT: begin
				s1_d.dres = {8'h00, b};
				s1_d.dz   = b & mask;
			end
			OP_RES: s1_d.dres = {8'h00, b & ~mask};
			OP_SET: s1_d.dres = {8'h00, b | mask};
			OP_INC: begin
				s1_d.opa = {8'h00, b};
				s1_d.cin = 1'b1;
			end
			OP_DEC: begin
				// b - 1 as b + 0xff
				s1_d.opa = {8'h00, b};
				s1_d.opb = {8'h00, 8'hff};
			end
			OP_ADD16: begin
				s1_d.opa = req.x;
				s1_d.opb = req.y;
			end
			OP_ADDSP: begin
				s1_d.opa = req.x;
				s1_d.opb = {{8{b[7]}}, b};
			end
			default: s1_d.dres = req.x;
		endcase
		// logic and shift groups take zero from their own result
		if ((req.op != OP_BIT) && (req.op != OP_DAA)) s1_d.dz = s1_d.dres[7:0];
	end

	// ---------------------------------------------------------------
	// stage 2: shared adder, carries tapped at bits 4, 8, 12 and 16
	// ---------------------------------------------------------------
	always_comb begin
		logic [16:0] sum;
		logic [15:0] cvec;
		sum  = {1'b0, pipe_s1.opa} + {1'b0, pipe_s1.opb} + {16'h0000, pipe_s1.cin};
		// carry into each bit position
		cvec = pipe_s1.opa ^ pipe_s1.opb ^ sum[15:0];
		s2_d.op   = pipe_s1.op;
		s2_d.f    = pipe_s1.f;
		s2_d.res  = {8'h00, sum[7:0]};
		s2_d.zval = sum[7:0];
		s2_d.h    = cvec[4];
		s2_d.c    = cvec[8];
		case (pipe_s1.op)
			OP_ADD, OP_ADC, OP_INC: ;
			OP_SUB, OP_SBC, OP_DEC: begin
				s2_d.h = !cvec[4];
				s2_d.c = !cvec[8];
			end
			OP_CP: begin
				s2_d.res = {8'h00, pipe_s1.opa[7:0]};
				s2_d.h   = !cvec[4];
				s2_d.c   = !cvec[8];
			end
			OP_DAA: s2_d.c = pipe_s1.dcy;
			OP_ADD16: begin
				s2_d.res = sum[15:0];
				s2_d.h   = cvec[12];
				s2_d.c   = sum[16];
			end
			OP_ADDSP: s2_d.res = sum[15:0];
			default: begin
				s2_d.res  = pipe_s1.dres;
				s2_d.zval = pipe_s1.dz;
				s2_d.h    = 1'b0;
				s2_d.c    = pipe_s1.dcy;
			end
		endcase
	end

	// ---------------------------------------------------------------
	// stage 3: zero detect and flag assembly per op group
	// ---------------------------------------------------------------
	always_comb begin
		logic   z;
		flags_t f;
		z = (pipe_s2.zval == 8'h00);
		f = pipe_s2.f;
		s3_d.result    = pipe_s2.res;
		s3_d.flags_out = f;
		case (pipe_s2.op)
			OP_ADD, OP_ADC:
				s3_d.flags_out = '{z: z, n: 1'b0, h: pipe_s2.h, c: pipe_s2.c};
			OP_SUB, OP_SBC, OP_CP:
				s3_d.flags_out = '{z: z, n: 1'b1, h: pipe_s2.h, c: pipe_s2.c};
			OP_AND:
				s3_d.flags_out = '{z: z, n: 1'b0, h: 1'b1, c: 1'b0};
			OP_XOR, OP_OR:
				s3_d.flags_out = '{z: z, n: 1'b0, h: 1'b0, c: 1'b0};
			OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL:
				s3_d.flags_out = '{z: z, n: 1'b0, h: 1'b0, c: pipe_s2.c};
			OP_RLCA, OP_RRCA, OP_RLA, OP_RRA:
				s3_d.flags_out = '{z: 1'b0, n: 1'b0, h: 1'b0, c: pipe_s2.c};
			OP_DAA:
				s3_d.flags_out = '{z: z, n: f.n, h: 1'b0, c: pipe_s2.c};
			OP_CPL:
				s3_d.flags_out = '{z: f.z, n: 1'b1, h: 1'b1, c: f.c};
			OP_SCF:
				s3_d.flags_out = '{z: f.z, n: 1'b0, h: 1'b0, c: 1'b1};
			OP_CCF:
				s3_d.flags_out = '{z: f.z, n: 1'b0, h: 1'b0, c: !f.c};
			OP_BIT:
				s3_d.flags_out = '{z: z, n: 1'b0, h: 1'b1, c: f.c};
			OP_INC:
				s3_d.flags_out = '{z: z, n: 1'b0, h: pipe_s2.h, c: f.c};
			OP_DEC:
				s3_d.flags_out = '{z: z, n: 1'b1, h: pipe_s2.h, c: f.c};
			OP_ADD16:
				s3_d.flags_out = '{z: f.z, n: 1'b0, h: pipe_s2.h, c: pipe_s2.c};
			OP_ADDSP:
				s3_d.flags_out = '{z: 1'b0, n: 1'b0, h: pipe_s2.h, c: pipe_s2.c};
			default: s3_d.flags_out = f;   // res, set and unused codes keep flags
		endcase
	end

	// ---------------------------------------------------------------
	// valid bits, cleared on reset
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= req_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// payload stages, no reset needed
	always_ff @(posedge clk) begin
		if (en1) pipe_s1 <= s1_d;
		if (en2) pipe_s2 <= s2_d;
		if (en3) rsp_s3  <= s3_d;
	end

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	// a beat held in stage 1 behind a stall keeps its contents
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !en2 |=> v_s1 && $stable(pipe_s1))
		else $error("stage 1 beat changed while stalled");

	// a beat held in stage 2 behind a stall keeps its contents
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !en3 |=> v_s2 && $stable(pipe_s2))
		else $error("stage 2 beat changed while stalled");

	// an empty first stage always takes a new beat
	a_s1_open: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> req_ready)
		else $error("req_ready low with stage 1 empty");

	// a stage 2 beat moves into a free output register in the next cycle
	a_s2_drain: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !v_s3 |=> rsp_valid)
		else $error("stage 2 beat lost on its way to the output");

	// accepted beat with free pipeline is still in flight, in stage 2 or the output register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !v_s1 && !v_s2 && !v_s3 |=> ##1 v_s3 || v_s2)
		else $error("accepted beat vanished from the pipeline");

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the eight-bit alu with flags
// a short table of hand-picked beats (one per op code, plus extremes and the
// cases with odd flag rules) is followed by random beats; every response is
// checked field by field, in order, against a behavioural model of the alu or
// the hand-typed answer, while both handshake sides idle and stall at random
// ----------------------------------------------------------------------------
module tb_top
	import alu8f_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD = 20;
	localparam int IDLE_PCT   = 21;
	localparam int NUM_RANDOM = 716;

	// op code 31 is not decoded: x and the flags come straight back
	localparam logic [4:0] OP_UNUSED = 5'd31;

	// sender: quiet stretch and pause point, in random beats
	localparam int SEND_QUIET_FROM = 200;
	localparam int SEND_QUIET_TO   = 350;
	localparam int SEND_PAUSE_AT   = 400;

	// receiver: hold-off and quiet stretch, in cycles after reset
	localparam int HOLD_AT        = 150;
	localparam int HOLD_CYCLES    = 60;
	localparam int RECV_QUIET_FROM = 700;
	localparam int RECV_QUIET_TO   = 950;

	// pipeline is three deep, a few spare cycles at the end are plenty
	localparam int TAIL_CYCLES  = 8;
	localparam int DRAIN_LIMIT  = 2000;

	// one row of the directed table: a request beat and, where the answer is
	// obvious, the response typed in by hand
	typedef struct packed {
		alu_req_t beat;
		logic     typed;
		alu_rsp_t want;
	} stim_row_t;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     req_valid;
	logic     req_ready;
	alu_req_t req;
	logic     rsp_valid;
	logic     rsp_ready;
	alu_rsp_t rsp;

	alu_rsp_t results_due[$];
	int       fail_count = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	eight_bit_alu_with_flags_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// behavioural alu: what one request beat should give back
	function automatic alu_rsp_t alu_eval(alu_req_t r);
		logic [7:0]  a;
		logic [7:0]  b;
		logic        c;
		logic        cin;
		logic [8:0]  sum9;
		logic [4:0]  nib;
		logic [7:0]  res8;
		logic [7:0]  corr;
		logic        cy;
		logic [12:0] sum13;
		logic [16:0] sum17;
		alu_rsp_t    o;
		a = r.x[7:0];
		b = r.y[7:0];
		c = r.flags_in.c;
		res8 = 8'h00;
		o.result = r.x;
		o.flags_out = r.flags_in;
		case (r.op)
			OP_ADD, OP_ADC: begin
				cin = (r.op == OP_ADC) ? c : 1'b0;
				sum9 = {1'b0, a} + {1'b0, b} + {8'h00, cin};
				nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cin};
				res8 = sum9[7:0];
				o.result = {8'h00, res8};
				o.flags_out = {res8 == 8'h00, 1'b0, nib[4], sum9[8]};
			end
			OP_SUB, OP_SBC, OP_CP: begin
				// cp throws the difference away but keeps its flags
				cin = (r.op == OP_SBC) ? c : 1'b0;
				res8 = a - b - {7'h00, cin};
				o.result = {8'h00, (r.op == OP_CP) ? a : res8};
				o.flags_out = {res8 == 8'h00, 1'b1,
					{1'b0, a[3:0]} < {1'b0, b[3:0]} + {4'h0, cin},
					{1'b0, a} < {1'b0, b} + {8'h00, cin}};
			end
			OP_AND: begin
				res8 = a & b;
				o.result = {8'h00, res8};
				o.flags_out = {res8 == 8'h00, 1'b0, 1'b1, 1'b0};
			end
			OP_XOR, OP_OR: begin
				res8 = (r.op == OP_XOR) ? (a ^ b) : (a | b);
				o.result = {8'h00, res8};
				o.flags_out = {res8 == 8'h00, 3'b000};
			end
			OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL: begin
				case (r.op)
					OP_RLC:  begin cy = b[7]; res8 = {b[6:0], b[7]}; end
					OP_RRC:  begin cy = b[0]; res8 = {b[0], b[7:1]}; end
					OP_RL:   begin cy = b[7]; res8 = {b[6:0], c}; end
					OP_RR:   begin cy = b[0]; res8 = {c, b[7:1]}; end
					OP_SLA:  begin cy = b[7]; res8 = {b[6:0], 1'b0}; end
					OP_SRA:  begin cy = b[0]; res8 = {b[7], b[7:1]}; end
					OP_SWAP: begin cy = 1'b0; res8 = {b[3:0], b[7:4]}; end
					default: begin cy = b[0]; res8 = {1'b0, b[7:1]}; end
				endcase
				o.result = {8'h00, res8};
				o.flags_out = {res8 == 8'h00, 2'b00, cy};
			end
			OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
				// accumulator rotates always clear z
				case (r.op)
					OP_RLCA: begin cy = a[7]; res8 = {a[6:0], a[7]}; end
					OP_RRCA: begin cy = a[0]; res8 = {a[0], a[7:1]}; end
					OP_RLA:  begin cy = a[7]; res8 = {a[6:0], c}; end
					default: begin cy = a[0]; res8 = {c, a[7:1]}; end
				endcase
				o.result = {8'h00, res8};
				o.flags_out = {3'b000, cy};
			end
			OP_DAA: begin
				corr = 8'h00;
				cy = c;
				if (r.flags_in.n) begin
					if (r.flags_in.h)
						corr = corr | DAA_LO;
					if (c)
						corr = corr | DAA_HI;
					res8 = a - corr;
				end else begin
					if (r.flags_in.h || a[3:0] > NIB_LIMIT)
						corr = corr | DAA_LO;
					if (c || a > DAA_LIMIT) begin
						corr = corr | DAA_HI;
						cy = 1'b1;
					end
					res8 = a + corr;
				end
				o.result = {8'h00, res8};
				o.flags_out = {res8 == 8'h00, r.flags_in.n, 1'b0, cy};
			end
			OP_CPL: begin
				o.result = {8'h00, ~a};
				o.flags_out = {r.flags_in.z, 1'b1, 1'b1, c};
			end
			OP_SCF, OP_CCF: begin
				o.result = {8'h00, a};
				o.flags_out = {r.flags_in.z, 2'b00, (r.op == OP_SCF) ? 1'b1 : ~c};
			end
			OP_BIT: begin
				o.result = {8'h00, b};
				o.flags_out = {~b[r.bit_sel], 1'b0, 1'b1, c};
			end
			OP_RES, OP_SET: begin
				// flags pass through untouched
				res8 = (r.op == OP_RES) ? (b & ~(8'h01 << r.bit_sel))
				                        : (b | (8'h01 << r.bit_sel));
				o.result = {8'h00, res8};
			end
			OP_INC: begin
				res8 = b + 8'h01;
				o.result = {8'h00, res8};
				o.flags_out = {res8 == 8'h00, 1'b0, b[3:0] == 4'hF, c};
			end
			OP_DEC: begin
				res8 = b - 8'h01;
				o.result = {8'h00, res8};
				o.flags_out = {res8 == 8'h00, 1'b1, b[3:0] == 4'h0, c};
			end
			OP_ADD16: begin
				sum17 = {1'b0, r.x} + {1'b0, r.y};
				sum13 = {1'b0, r.x[11:0]} + {1'b0, r.y[11:0]};
				o.result = sum17[15:0];
				o.flags_out = {r.flags_in.z, 1'b0, sum13[12], sum17[16]};
			end
			OP_ADDSP: begin
				// carries come from the unsigned low-byte add
				nib = {1'b0, r.x[3:0]} + {1'b0, b[3:0]};
				sum9 = {1'b0, r.x[7:0]} + {1'b0, b};
				o.result = r.x + {{8{b[7]}}, b};
				o.flags_out = {2'b00, nib[4], sum9[8]};
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	function automatic stim_row_t calc_row(logic [4:0] op, logic [15:0] x, logic [15:0] y,
		logic [2:0] bs, logic [3:0] f);
		stim_row_t row;
		row.beat = {op, x, y, bs, f};
		row.typed = 1'b0;
		row.want = '0;
		return row;
	endfunction

	function automatic stim_row_t fixed_row(logic [4:0] op, logic [15:0] x, logic [15:0] y,
		logic [2:0] bs, logic [3:0] f, logic [15:0] res, logic [3:0] fo);
		stim_row_t row;
		row.beat = {op, x, y, bs, f};
		row.typed = 1'b1;
		row.want = {res, fo};
		return row;
	endfunction

	// operands lean towards the byte and nibble boundaries now and then
	function automatic logic [15:0] rand_operand();
		if ($urandom_range(0, 7) != 0)
			return 16'($urandom);
		case ($urandom_range(0, 7))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return 16'h00FF;
			3:       return 16'hFF00;
			4:       return 16'h000F;
			5:       return 16'h0FFF;
			6:       return 16'h0080;
			default: return 16'h8000;
		endcase
	endfunction

	// offer one beat: maybe idle first, then hold it until the block takes it,
	// and book the response it is owed at the edge of acceptance
	task automatic offer_beat(alu_req_t beat, logic typed, alu_rsp_t want, bit quiet);
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= beat;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		results_due.push_back(typed ? want : alu_eval(beat));
	endtask

	// stimulus: reset, directed table, random beats, then drain and verdict
	initial begin : stimulus
		stim_row_t dir_table[$];
		alu_req_t  beat;
		int        drain;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// byte wrap, half carry and carry all at once
		dir_table.push_back(fixed_row(OP_ADD, 16'h00FF, 16'h0001, 3'd0, 4'b0000,
			16'h0000, 4'b1011));
		// adc with carry in, high bytes of x and y must be ignored
		dir_table.push_back(calc_row(OP_ADC, 16'hAB0F, 16'hCDF0, 3'd0, 4'b0001));
		dir_table.push_back(fixed_row(OP_SUB, 16'h0000, 16'h0001, 3'd0, 4'b0000,
			16'h00FF, 4'b0111));
		dir_table.push_back(calc_row(OP_SBC, 16'h0010, 16'h000F, 3'd0, 4'b0001));
		dir_table.push_back(fixed_row(OP_AND, 16'hFFF0, 16'hFF0F, 3'd0, 4'b0000,
			16'h0000, 4'b1010));
		dir_table.push_back(fixed_row(OP_XOR, 16'h00FF, 16'h00FF, 3'd0, 4'b1111,
			16'h0000, 4'b1000));
		dir_table.push_back(calc_row(OP_OR, 16'h0080, 16'h0001, 3'd0, 4'b0000));
		// compare returns the accumulator untouched
		dir_table.push_back(fixed_row(OP_CP, 16'h1242, 16'h3442, 3'd0, 4'b0000,
			16'h0042, 4'b1100));
		dir_table.push_back(calc_row(OP_RLC, 16'h0000, 16'hFF80, 3'd0, 4'b0000));
		dir_table.push_back(calc_row(OP_RRC, 16'hFFFF, 16'h0001, 3'd0, 4'b0000));
		dir_table.push_back(calc_row(OP_RL, 16'h0000, 16'h0080, 3'd0, 4'b0001));
		dir_table.push_back(fixed_row(OP_RR, 16'h0000, 16'h0001, 3'd0, 4'b0000,
			16'h0000, 4'b1001));
		dir_table.push_back(calc_row(OP_SLA, 16'h0000, 16'h00FF, 3'd0, 4'b0000));
		dir_table.push_back(calc_row(OP_SRA, 16'h0000, 16'h0080, 3'd0, 4'b0000));
		dir_table.push_back(calc_row(OP_SWAP, 16'h0000, 16'h00F0, 3'd0, 4'b0001));
		dir_table.push_back(calc_row(OP_SRL, 16'h0000, 16'h0001, 3'd0, 4'b0000));
		dir_table.push_back(calc_row(OP_RLCA, 16'h0080, 16'h0000, 3'd0, 4'b1110));
		dir_table.push_back(calc_row(OP_RRCA, 16'hFF01, 16'h0000, 3'd0, 4'b0000));
		dir_table.push_back(calc_row(OP_RLA, 16'h0000, 16'h0000, 3'd0, 4'b0001));
		dir_table.push_back(calc_row(OP_RRA, 16'h0001, 16'h0000, 3'd0, 4'b0000));
		// decimal adjust after an add that overflowed both digits, then after
		// a subtract with both borrows set
		dir_table.push_back(calc_row(OP_DAA, 16'h009A, 16'h0000, 3'd0, 4'b0000));
		dir_table.push_back(calc_row(OP_DAA, 16'h0000, 16'h0000, 3'd0, 4'b0111));
		dir_table.push_back(fixed_row(OP_CPL, 16'hAA55, 16'h0000, 3'd0, 4'b0000,
			16'h00AA, 4'b0110));
		// scf and ccf hand the accumulator byte back as it was, high byte cleared
		dir_table.push_back(calc_row(OP_SCF, 16'h1234, 16'h0000, 3'd0, 4'b1110));
		dir_table.push_back(calc_row(OP_CCF, 16'h0077, 16'h0000, 3'd0, 4'b0001));
		// bit returns the operand byte untouched
		dir_table.push_back(calc_row(OP_BIT, 16'h0000, 16'h0080, 3'd7, 4'b0000));
		dir_table.push_back(calc_row(OP_RES, 16'h0000, 16'h00FF, 3'd7, 4'b1010));
		dir_table.push_back(calc_row(OP_SET, 16'h0000, 16'hFF00, 3'd0, 4'b0101));
		dir_table.push_back(calc_row(OP_INC, 16'h0000, 16'h00FF, 3'd0, 4'b0001));
		dir_table.push_back(calc_row(OP_DEC, 16'h0000, 16'h0000, 3'd0, 4'b0000));
		// sixteen-bit add: z kept, carries from bits 11 and 15
		dir_table.push_back(calc_row(OP_ADD16, 16'hFFFF, 16'h0001, 3'd0, 4'b1111));
		// sp plus a negative and a positive displacement
		dir_table.push_back(calc_row(OP_ADDSP, 16'h0000, 16'h00FF, 3'd0, 4'b1111));
		dir_table.push_back(calc_row(OP_ADDSP, 16'hFFFF, 16'h007F, 3'd0, 4'b0000));
		// undecoded op code echoes x and the flags
		dir_table.push_back(fixed_row(OP_UNUSED, 16'hBEEF, 16'hFFFF, 3'd7, 4'b0101,
			16'hBEEF, 4'b0101));

		foreach (dir_table[i])
			offer_beat(dir_table[i].beat, dir_table[i].typed, dir_table[i].want, 1'b0);

		for (int n = 0; n < NUM_RANDOM; n++) begin
			// let the pipeline run dry once, mid-stream
			if (n == SEND_PAUSE_AT) begin
				req_valid <= 1'b0;
				while (results_due.size() != 0)
					@(posedge clk);
			end
			beat.op = 5'($urandom_range(0, 31));
			beat.x = rand_operand();
			beat.y = rand_operand();
			beat.bit_sel = 3'($urandom_range(0, 7));
			beat.flags_in = 4'($urandom_range(0, 15));
			offer_beat(beat, 1'b0, '0, n >= SEND_QUIET_FROM && n < SEND_QUIET_TO);
		end
		req_valid <= 1'b0;

		// wait for the last responses, bounded so a lost beat still ends the run
		drain = 0;
		while (results_due.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (results_due.size() != 0) begin
			$display("%0t: %0d response beats never arrived", $time, results_due.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// receiver: random back-pressure, one long hold-off so the three stages
	// fill and req_ready drops, and a quiet stretch with no stalls at all
	initial begin : receiver
		int cyc;
		rsp_ready <= 1'b0;
		cyc = 0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			cyc++;
			if (cyc == HOLD_AT) begin
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				rsp_ready <= (cyc >= RECV_QUIET_FROM && cyc < RECV_QUIET_TO) ||
					$urandom_range(0, 99) >= IDLE_PCT;
			end
			@(posedge clk);
		end
	end

	// response check: oldest booked response against each beat taken
	always @(posedge clk) begin : rsp_check
		alu_rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (results_due.size() == 0) begin
				$display("%0t: response beat with none expected, got result %h flags %b",
					$time, rsp.result, rsp.flags_out);
				fail_count++;
			end else begin
				want = results_due.pop_front();
				if (rsp.result !== want.result) begin
					$display("%0t: result mismatch, expected %h got %h",
						$time, want.result, rsp.result);
					fail_count++;
				end
				if (rsp.flags_out !== want.flags_out) begin
					$display("%0t: flags mismatch, expected %b got %b",
						$time, want.flags_out, rsp.flags_out);
					fail_count++;
				end
			end
		end
	end

	// watchdog, far beyond the slowest legal run
	initial begin : watchdog
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire
